/* rtl/mvg_pkg.sv */
package mvg_pkg;

    // Field widths of the stream payload
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 17;
    localparam int STORED_W = 16;
    localparam int PRES_W   = 17;
    localparam int VOI_W    = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Configuration register widths
    localparam int OFFSET_W = 16;
    localparam int SLOPE_W  = 24;
    localparam int GAIN_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default geometry
    localparam int VOI_DEPTH_DEF     = 4096;
    localparam int DISPLAY_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int OUT_FIFO_DEPTH    = 16;

    // Reset values of the configuration registers
    localparam int                  VOI_ENTRIES_RESET   = 4096;
    localparam logic [SLOPE_W-1:0]  INVERSE_SLOPE_RESET = 24'd1;
    localparam logic [GAIN_W-1:0]   VOI_GAIN_RESET      = 32'd65537;

    // Q16 arithmetic
    localparam int                 Q16_SHIFT = 16;
    localparam logic [PRES_W-1:0]  Q16_ONE   = 17'h10000;
    localparam logic [PRES_W-1:0]  Q16_HALF  = 17'h08000;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_VOI_WR  = 2'd1,
        CMD_DISP_WR = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESCALE_OFFSET  = 3'd0,
        REG_INVERSE_SLOPE   = 3'd1,
        REG_VOI_ENTRIES     = 3'd2,
        REG_VOI_GAIN        = 3'd3,
        REG_DISPLAY_ENTRIES = 3'd4
    } cfg_reg_t;

    // One transaction travelling down the pipeline
    typedef struct packed {
        logic               valid;
        cmd_t               cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } item_t;

    // One finished pixel result
    typedef struct packed {
        logic              valid;
        logic [PRES_W-1:0] value;
    } res_t;

endpackage

/* rtl/modality_voi_gsdf_pixel_map.sv */
// Pixel mapper: modality rescale, VOI table lookup and optional interpolated
// display table, one stream transaction per clock while s_tready is high.
// Every input transaction (pixel, VOI table write, display table write)
// enters a single in-order pipeline; table writes commit at the same stage
// where pixels read that table, so a pixel always sees every write sent
// before it. A pixel result passes the registered stages a to j to the
// output buffer and can be taken from it in the next cycle. This rate is
// set by the single pipeline and the one read per table per cycle (the
// display table is kept in two copies so both interpolation neighbours are
// read together). The 16-entry output buffer holds results while the sink
// stalls; input is accepted as long as fewer than 16 pixels are in flight
// or buffered. Tables come up undefined and have no clearing pass: load
// every entry that will be read before sending pixels. Configuration must be
// written only while no transaction is in flight; the block does not check.
module modality_voi_gsdf_pixel_map
    import mvg_pkg::*;
#(
    parameter int VOI_DEPTH     = VOI_DEPTH_DEF,
    parameter int DISPLAY_DEPTH = DISPLAY_DEPTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // command, table_index, table_value, stored_value
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // presentation_value
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int VAW = $clog2(VOI_DEPTH);
    localparam int DAW = $clog2(DISPLAY_DEPTH);
    localparam int VOI_RESET_N = (VOI_ENTRIES_RESET > VOI_DEPTH) ? VOI_DEPTH
                                                                 : VOI_ENTRIES_RESET;

    // Configuration, with entry counts held as last usable index
    logic signed [OFFSET_W-1:0] rescale_offset_reg;
    logic [SLOPE_W-1:0]         inverse_slope_reg;
    logic [VAW-1:0]             voi_last_reg;
    logic [VAW-1:0]             voi_last_next;
    logic [GAIN_W-1:0]          voi_gain_reg;
    logic                       disp_on_reg;
    logic [DAW-1:0]             disp_last_reg;
    logic [DAW-1:0]             disp_last_next;
    logic [16:0]                voi_n;
    logic [16:0]                disp_n;

    assign voi_n  = 17'(cfg_data[12:0]);
    assign disp_n = 17'(cfg_data[10:0]);

    // Saturate entry counts to the table depths
    always_comb
    begin
        if (voi_n == '0)
        begin
            voi_last_next = '0;
        end
        else if (voi_n > 17'(VOI_DEPTH))
        begin
            voi_last_next = VAW'(VOI_DEPTH - 1);
        end
        else
        begin
            voi_last_next = VAW'(voi_n - 17'd1);
        end

        if (disp_n > 17'(DISPLAY_DEPTH))
        begin
            disp_last_next = DAW'(DISPLAY_DEPTH - 1);
        end
        else
        begin
            disp_last_next = DAW'(disp_n - 17'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rescale_offset_reg <= '0;
            inverse_slope_reg  <= INVERSE_SLOPE_RESET;
            voi_last_reg       <= VAW'(VOI_RESET_N - 1);
            voi_gain_reg       <= VOI_GAIN_RESET;
            disp_on_reg        <= 1'b0;
            disp_last_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RESCALE_OFFSET:  rescale_offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_INVERSE_SLOPE:   inverse_slope_reg  <= cfg_data[SLOPE_W-1:0];
                REG_VOI_ENTRIES:     voi_last_reg       <= voi_last_next;
                REG_VOI_GAIN:        voi_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_DISPLAY_ENTRIES:
                begin
                    disp_on_reg   <= |cfg_data[10:0];
                    disp_last_reg <= disp_last_next;
                end
                default: ;
            endcase
        end
    end

    // Unpack the input transaction
    item_t                      in_item;
    logic signed [STORED_W-1:0] in_stored;
    logic                       in_take;
    logic                       room;

    assign s_tready = room;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_item.valid = in_take;
        in_item.cmd   = cmd_t'(s_tdata[1:0]);
        in_item.index = s_tdata[13:2];
        in_item.value = s_tdata[30:14];
        in_stored     = s_tdata[46:31];
    end

    item_t       voi_item;
    logic [31:0] voi_level;
    res_t        result;

    mvg_voi_stage #(
        .VOI_DEPTH (VOI_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_voi_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (in_item),
        .stored_value   (in_stored),
        .rescale_offset (rescale_offset_reg),
        .inverse_slope  (inverse_slope_reg),
        .voi_last       (voi_last_reg),
        .voi_gain       (voi_gain_reg),
        .out_item       (voi_item),
        .out_level      (voi_level)
    );

    mvg_disp_stage #(
        .DISPLAY_DEPTH (DISPLAY_DEPTH)
    ) u_disp_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (voi_item),
        .in_level  (voi_level),
        .disp_on   (disp_on_reg),
        .disp_last (disp_last_reg),
        .result    (result)
    );

    mvg_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .take_pixel (in_take && (in_item.cmd == CMD_PIXEL)),
        .room       (room),
        .push       (result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* rtl/mvg_ram.sv */
module mvg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/mvg_voi_stage.sv */
module mvg_voi_stage
    import mvg_pkg::*;
#(
    parameter int VOI_DEPTH = VOI_DEPTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  item_t                        in_item,
    input  logic signed [STORED_W-1:0]   stored_value,
    input  logic signed [OFFSET_W-1:0]   rescale_offset,
    input  logic [SLOPE_W-1:0]           inverse_slope,
    input  logic [$clog2(VOI_DEPTH)-1:0] voi_last,
    input  logic [GAIN_W-1:0]            voi_gain,
    output item_t                        out_item,
    output logic [31:0]                  out_level
);

    localparam int VAW    = $clog2(VOI_DEPTH);
    localparam int NORM_W = STORED_W + SLOPE_W;
    localparam int PROD_W = FRAC_BITS + VAW;
    localparam int WORD_W = VOI_W + GAIN_W;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);

    // Stage a: difference from the intercept
    item_t                 a_item_reg;
    logic [STORED_W-1:0]   a_mag_reg;
    logic                  a_pos_reg;
    logic signed [16:0]    diff;

    assign diff = {stored_value[STORED_W-1], stored_value}
                - {rescale_offset[OFFSET_W-1], rescale_offset};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_item_reg <= '0;
        end
        else
        begin
            a_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= diff[STORED_W-1:0];
        a_pos_reg <= !diff[16] && (|diff[STORED_W-1:0]);
    end

    // Stage b: scale by the reciprocal slope
    item_t               b_item_reg;
    logic [NORM_W-1:0]   b_norm_reg;
    logic [NORM_W-1:0]   b_norm_next;
    logic                b_pos_reg;

    assign b_norm_next = a_mag_reg * inverse_slope;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_item_reg <= '0;
        end
        else
        begin
            b_item_reg <= a_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_norm_reg <= b_norm_next;
        b_pos_reg  <= a_pos_reg;
    end

    // Stage c: scale the fraction by entries minus one; a value of one or more
    // saturates to the last entry
    item_t               c_item_reg;
    logic [PROD_W-1:0]   c_prod_reg;
    logic [PROD_W-1:0]   c_prod_next;
    logic                c_big_reg;
    logic                c_pos_reg;

    assign c_prod_next = b_norm_reg[FRAC_BITS-1:0] * voi_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_item_reg <= '0;
        end
        else
        begin
            c_item_reg <= b_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_prod_reg <= c_prod_next;
        c_big_reg  <= |b_norm_reg[NORM_W-1:FRAC_BITS];
        c_pos_reg  <= b_pos_reg && (|b_norm_reg);
    end

    // Stage d: round to an index and access the VOI table
    logic [PROD_W:0]     round_sum;
    logic [VAW-1:0]      voi_idx;
    logic                voi_we;
    logic                voi_re;
    logic [VOI_W-1:0]    voi_word;
    item_t               d_item_reg;

    assign round_sum = {1'b0, c_prod_reg} + ROUND_HALF;

    always_comb
    begin
        if (!c_pos_reg)
        begin
            voi_idx = '0;
        end
        else if (c_big_reg)
        begin
            voi_idx = voi_last;
        end
        else
        begin
            voi_idx = round_sum[FRAC_BITS +: VAW];
        end
    end

    // Writes commit at the same stage the reads issue, so order is kept
    assign voi_we = c_item_reg.valid && (c_item_reg.cmd == CMD_VOI_WR)
                 && (17'(c_item_reg.index) < 17'(VOI_DEPTH));
    assign voi_re = c_item_reg.valid && (c_item_reg.cmd == CMD_PIXEL);

    mvg_ram #(
        .WIDTH (VOI_W),
        .DEPTH (VOI_DEPTH)
    ) u_voi_ram (
        .clk   (clk),
        .we    (voi_we),
        .waddr (VAW'(c_item_reg.index)),
        .wdata (c_item_reg.value[VOI_W-1:0]),
        .re    (voi_re),
        .raddr (voi_idx),
        .rdata (voi_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_item_reg <= '0;
        end
        else
        begin
            d_item_reg <= c_item_reg;
        end
    end

    // Stage e: apply the full-scale gain
    item_t               e_item_reg;
    logic [WORD_W-1:0]   e_prod_reg;
    logic [WORD_W-1:0]   e_prod_next;

    assign e_prod_next = voi_word * voi_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_item_reg <= '0;
        end
        else
        begin
            e_item_reg <= d_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_prod_reg <= e_prod_next;
    end

    // Stage f: round back to Q16
    item_t               f_item_reg;
    logic [31:0]         f_level_reg;
    logic [WORD_W-1:0]   level_sum;

    assign level_sum = e_prod_reg + WORD_W'(Q16_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_item_reg <= '0;
        end
        else
        begin
            f_item_reg <= e_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_level_reg <= level_sum[Q16_SHIFT +: 32];
    end

    assign out_item  = f_item_reg;
    assign out_level = f_level_reg;

endmodule

/* rtl/mvg_disp_stage.sv */
module mvg_disp_stage
    import mvg_pkg::*;
#(
    parameter int DISPLAY_DEPTH = DISPLAY_DEPTH_DEF
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  item_t                            in_item,
    input  logic [31:0]                      in_level,
    input  logic                             disp_on,
    input  logic [$clog2(DISPLAY_DEPTH)-1:0] disp_last,
    output res_t                             result
);

    localparam int DAW      = $clog2(DISPLAY_DEPTH);
    localparam int SCALED_W = Q16_SHIFT + DAW;
    localparam int LO_W     = 2 * VALUE_W;
    localparam int HI_W     = Q16_SHIFT + VALUE_W;
    localparam int SUM_W    = LO_W + 1;

    // Stage g: bypass clamp and position within the display table
    item_t                 g_item_reg;
    logic                  g_zero_reg;
    logic                  g_top_reg;
    logic [PRES_W-1:0]     g_bypass_reg;
    logic [PRES_W-1:0]     g_bypass_next;
    logic [SCALED_W-1:0]   g_scaled_reg;
    logic [SCALED_W-1:0]   g_scaled_next;

    assign g_bypass_next = (in_level > 32'(Q16_ONE)) ? Q16_ONE : in_level[PRES_W-1:0];
    assign g_scaled_next = in_level[Q16_SHIFT-1:0] * disp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_item_reg <= '0;
        end
        else
        begin
            g_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk)
    begin
        g_zero_reg   <= (in_level == '0);
        g_top_reg    <= |in_level[31:Q16_SHIFT];
        g_bypass_reg <= g_bypass_next;
        g_scaled_reg <= g_scaled_next;
    end

    // Stage h: pick the two neighbouring entries and read both copies
    logic [DAW-1:0]        lo_addr;
    logic [DAW-1:0]        hi_addr;
    logic [Q16_SHIFT-1:0]  frac;
    logic                  disp_we;
    logic                  disp_re;
    logic [VALUE_W-1:0]    lo_entry;
    logic [VALUE_W-1:0]    hi_entry;
    item_t                 h_item_reg;
    logic [Q16_SHIFT-1:0]  h_frac_reg;
    logic [PRES_W-1:0]     h_bypass_reg;

    always_comb
    begin
        if (g_zero_reg)
        begin
            lo_addr = '0;
            frac    = '0;
        end
        else if (g_top_reg)
        begin
            lo_addr = disp_last;
            frac    = '0;
        end
        else
        begin
            lo_addr = g_scaled_reg[SCALED_W-1:Q16_SHIFT];
            frac    = g_scaled_reg[Q16_SHIFT-1:0];
        end
        hi_addr = (lo_addr == disp_last) ? lo_addr : lo_addr + DAW'(1);
    end

    assign disp_we = g_item_reg.valid && (g_item_reg.cmd == CMD_DISP_WR)
                  && (17'(g_item_reg.index) < 17'(DISPLAY_DEPTH));
    assign disp_re = g_item_reg.valid && (g_item_reg.cmd == CMD_PIXEL);

    mvg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DISPLAY_DEPTH)
    ) u_disp_lo_ram (
        .clk   (clk),
        .we    (disp_we),
        .waddr (DAW'(g_item_reg.index)),
        .wdata (g_item_reg.value),
        .re    (disp_re),
        .raddr (lo_addr),
        .rdata (lo_entry)
    );

    mvg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DISPLAY_DEPTH)
    ) u_disp_hi_ram (
        .clk   (clk),
        .we    (disp_we),
        .waddr (DAW'(g_item_reg.index)),
        .wdata (g_item_reg.value),
        .re    (disp_re),
        .raddr (hi_addr),
        .rdata (hi_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_item_reg <= '0;
        end
        else
        begin
            h_item_reg <= g_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_frac_reg   <= frac;
        h_bypass_reg <= g_bypass_reg;
    end

    // Stage i: weight both neighbours
    item_t                 i_item_reg;
    logic [LO_W-1:0]       i_lo_reg;
    logic [HI_W-1:0]       i_hi_reg;
    logic [LO_W-1:0]       i_lo_next;
    logic [HI_W-1:0]       i_hi_next;
    logic [PRES_W-1:0]     i_bypass_reg;
    logic [PRES_W-1:0]     lo_weight;

    assign lo_weight = Q16_ONE - {1'b0, h_frac_reg};
    assign i_lo_next = lo_weight * lo_entry;
    assign i_hi_next = h_frac_reg * hi_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_item_reg <= '0;
        end
        else
        begin
            i_item_reg <= h_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i_lo_reg     <= i_lo_next;
        i_hi_reg     <= i_hi_next;
        i_bypass_reg <= h_bypass_reg;
    end

    // Stage j: sum, round, clamp and choose the path
    logic [SUM_W-1:0]             interp_sum;
    logic [SUM_W-Q16_SHIFT-1:0]   interp;
    logic [PRES_W-1:0]            interp_clamped;
    res_t                         result_reg;
    res_t                         result_next;

    assign interp_sum = SUM_W'(i_lo_reg) + SUM_W'(i_hi_reg) + SUM_W'(Q16_HALF);
    assign interp     = interp_sum[SUM_W-1:Q16_SHIFT];
    assign interp_clamped = (interp > (SUM_W-Q16_SHIFT)'(Q16_ONE))
                          ? Q16_ONE : interp[PRES_W-1:0];

    always_comb
    begin
        result_next.valid = i_item_reg.valid && (i_item_reg.cmd == CMD_PIXEL);
        result_next.value = disp_on ? interp_clamped : i_bypass_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/mvg_out_fifo.sv */
module mvg_out_fifo
    import mvg_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take_pixel,
    output logic                   room,
    input  res_t                   push,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PRES_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     head_next;
    logic [PW-1:0]     tail_reg;
    logic [PW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     credit_reg;
    logic [CW-1:0]     credit_next;
    logic              pop;

    // Credits cover every pixel in the pipeline plus every stored result
    assign room     = credit_reg < CW'(DEPTH);
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = OUT_TDATA_W'(entry_reg[head_reg]);
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        head_next   = pop ? ((head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1)) : head_reg;
        tail_next   = push.valid ? ((tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1))
                                 : tail_reg;
        count_next  = count_reg + CW'(push.valid) - CW'(pop);
        credit_next = credit_reg + CW'(take_pixel) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    // Store the result at the tail
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[tail_reg] <= push.value;
        end
    end

    a_push_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg < CW'(DEPTH)))
        else $error("result arrived with the output buffer full");

    a_credit_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        (credit_reg >= count_reg) && (credit_reg <= CW'(DEPTH)))
        else $error("credit count out of step with buffer fill");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.valid) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("buffer fill did not drop after a lone transaction out");

endmodule
